// ===== design/trsc_pkg.sv =====
// Package for the two-register stack CPU execute unit.
// Holds the command, opcode and access-kind encodings, the word width and the default memory size.
// No dependencies.
package trsc_pkg;

    // Default number of data memory words; must be a power of two.
    localparam int unsigned MEM_WORDS_DEF = 65536;

    localparam int unsigned WORD_W = 32;

    // Item command codes.
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_EXEC  = 1'b1;

    typedef enum logic [7:0] {
        OP_LDC    = 8'd0,
        OP_ADC    = 8'd1,
        OP_LDL    = 8'd2,
        OP_STL    = 8'd3,
        OP_LDNL   = 8'd4,
        OP_STNL   = 8'd5,
        OP_ADD    = 8'd6,
        OP_SUB    = 8'd7,
        OP_SHL    = 8'd8,
        OP_SHR    = 8'd9,
        OP_ADJ    = 8'd10,
        OP_A2SP   = 8'd11,
        OP_SP2A   = 8'd12,
        OP_CALL   = 8'd13,
        OP_RETURN = 8'd14,
        OP_BRZ    = 8'd15,
        OP_BRLZ   = 8'd16,
        OP_BR     = 8'd17,
        OP_HALT   = 8'd18
    } t_opcode;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } t_access;

endpackage

// ===== design/two_register_stack_cpu_execute.sv =====
// Execute unit of a two-register stack CPU; depends on trsc_pkg and trsc_ram.
// An accepted word waits in the execute slot and its result is registered when it finishes,
// which also waits for the result slot to be free. A new word is taken only once the
// previous one has left the slot, after its memory read and register update.
// Reset (synchronous, active low) clears A, B, PC, SP, the halt flag and both slots, then
// zeroes the data memory one word a cycle, all MEM_WORDS words, with input ready low.
module two_register_stack_cpu_execute #(
    parameter int unsigned MEM_WORDS = trsc_pkg::MEM_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [15:0]        i_addr,
    input  logic [31:0]        i_word,
    // Result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_acc_a,
    output logic signed [31:0] o_acc_b,
    output logic signed [31:0] o_prog_counter,
    output logic signed [31:0] o_stack_ptr,
    output logic               o_halted,
    output logic [1:0]         o_access_kind,
    output logic [15:0]        o_access_addr,
    output logic signed [31:0] o_access_old,
    output logic signed [31:0] o_access_data
);

    // Word address width; addresses wrap by keeping the low AW bits,
    // so MEM_WORDS is expected to be a power of two.
    localparam int unsigned AW = $clog2(MEM_WORDS);

    // Architectural state. These registers only change at reset or when a word finishes,
    // and a word only finishes when the result slot is free, so they double
    // as the result register for A, B, PC, SP and the halt flag.
    logic [31:0] r_a, r_b, r_pc, r_sp;
    logic        r_halt;

    // Execute slot: holds one accepted word while its memory read is in flight.
    logic          r_busy;
    logic          r_cmd;
    logic [31:0]   r_word;
    logic [AW-1:0] r_ea;

    // Result slot for the access log fields.
    logic          r_o_valid;
    logic [1:0]    r_kind;
    logic [15:0]   r_aaddr;
    logic [31:0]   r_aold;
    logic [31:0]   r_adata;

    // Clearing pass after reset.
    logic          r_clr_active;
    logic [AW-1:0] r_clr_idx;

    // Memory port signals.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    logic        accept;
    logic        finish;
    logic [31:0] in_val;
    logic [31:0] in_ea_sum;
    logic [7:0]  in_op;

    // Next-value signals produced when a word finishes.
    logic [31:0] n_a, n_b, n_pc, n_sp;
    logic        n_halt;
    logic [1:0]  n_kind;
    logic [31:0] n_aold, n_adata;
    logic        n_we;
    logic [31:0] n_wdata;
    logic [31:0] val;
    logic [31:0] pc_inc;
    logic [31:0] pc_branch;

    assign accept = i_valid && o_ready;
    // A word in the slot finishes once its read data is back and the result
    // slot is empty or being emptied in this cycle.
    assign finish = r_busy && (!r_o_valid || i_ready);

    // New words are taken only with the slot empty, which also keeps the read
    // of one word after the write-back of the one before it: no forwarding.
    assign o_ready = !r_busy && !r_clr_active;

    // Effective address of the incoming word, computed from the current state.
    assign in_op     = i_word[7:0];
    assign in_val    = {{8{i_word[31]}}, i_word[31:8]};
    assign in_ea_sum = (in_op == trsc_pkg::OP_LDL || in_op == trsc_pkg::OP_STL)
                       ? (r_sp + in_val) : (r_a + in_val);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_word <= i_word;
            if (i_cmd == trsc_pkg::CMD_STORE) begin
                r_ea <= AW'(i_addr);
            end else begin
                r_ea <= in_ea_sum[AW-1:0];
            end
        end
    end

    // Execute: combinational result of the word in the slot, using the read data.
    assign val       = {{8{r_word[31]}}, r_word[31:8]};
    assign pc_inc    = r_pc + 32'd1;
    assign pc_branch = pc_inc + val;

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_pc    = r_pc;
        n_sp    = r_sp;
        n_halt  = r_halt;
        n_kind  = trsc_pkg::ACC_NONE;
        n_aold  = '0;
        n_adata = '0;
        n_we    = 1'b0;
        n_wdata = r_word;
        if (r_cmd == trsc_pkg::CMD_STORE) begin
            // Memory load word: write only, nothing reported.
            n_we = 1'b1;
        end else if (!r_halt) begin
            n_pc = pc_inc;
            unique case (trsc_pkg::t_opcode'(r_word[7:0]))
                trsc_pkg::OP_LDC: begin
                    n_a = val;
                end
                trsc_pkg::OP_ADC: begin
                    n_a = r_a + val;
                end
                trsc_pkg::OP_LDL: begin
                    n_b     = r_a;
                    n_a     = mem_rdata;
                    n_kind  = trsc_pkg::ACC_READ;
                    n_adata = mem_rdata;
                end
                trsc_pkg::OP_STL: begin
                    n_aold  = mem_rdata;
                    n_we    = 1'b1;
                    n_wdata = r_a;
                    n_kind  = trsc_pkg::ACC_WRITE;
                    n_adata = r_a;
                    n_a     = r_b;
                end
                trsc_pkg::OP_LDNL: begin
                    n_a     = mem_rdata;
                    n_kind  = trsc_pkg::ACC_READ;
                    n_adata = mem_rdata;
                end
                trsc_pkg::OP_STNL: begin
                    n_aold  = mem_rdata;
                    n_we    = 1'b1;
                    n_wdata = r_b;
                    n_kind  = trsc_pkg::ACC_WRITE;
                    n_adata = r_b;
                end
                trsc_pkg::OP_ADD: begin
                    n_a = r_b + r_a;
                end
                trsc_pkg::OP_SUB: begin
                    n_a = r_b - r_a;
                end
                trsc_pkg::OP_SHL: begin
                    // Counts of 32 and above shift everything out.
                    n_a = (r_a[31:5] != '0) ? '0 : (r_b << r_a[4:0]);
                end
                trsc_pkg::OP_SHR: begin
                    // Counts of 32 and above leave only the sign fill.
                    n_a = (r_a[31:5] != '0) ? {32{r_b[31]}}
                                            : 32'($signed(r_b) >>> r_a[4:0]);
                end
                trsc_pkg::OP_ADJ: begin
                    n_sp = r_sp + val;
                end
                trsc_pkg::OP_A2SP: begin
                    n_sp = r_a;
                    n_a  = r_b;
                end
                trsc_pkg::OP_SP2A: begin
                    n_b = r_a;
                    n_a = r_sp;
                end
                trsc_pkg::OP_CALL: begin
                    n_b  = r_a;
                    n_a  = pc_inc;
                    n_pc = pc_branch;
                end
                trsc_pkg::OP_RETURN: begin
                    n_pc = r_a;
                    n_a  = r_b;
                end
                trsc_pkg::OP_BRZ: begin
                    if (r_a == '0) begin
                        n_pc = pc_branch;
                    end
                end
                trsc_pkg::OP_BRLZ: begin
                    if (r_a[31]) begin
                        n_pc = pc_branch;
                    end
                end
                trsc_pkg::OP_BR: begin
                    n_pc = pc_branch;
                end
                trsc_pkg::OP_HALT: begin
                    n_halt = 1'b1;
                end
                default: begin
                    // Unknown opcodes only advance PC.
                end
            endcase
        end
    end

    // Architectural state and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a          <= '0;
            r_b          <= '0;
            r_pc         <= '0;
            r_sp         <= '0;
            r_halt       <= 1'b0;
            r_busy       <= 1'b0;
            r_o_valid    <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else begin
            if (r_clr_active) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == AW'(MEM_WORDS - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (finish) begin
                r_a    <= n_a;
                r_b    <= n_b;
                r_pc   <= n_pc;
                r_sp   <= n_sp;
                r_halt <= n_halt;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (finish) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Access log fields of the result.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_kind  <= n_kind;
            r_aaddr <= (n_kind == trsc_pkg::ACC_NONE) ? 16'd0 : 16'(r_ea);
            r_aold  <= n_aold;
            r_adata <= n_adata;
        end
    end

    // Data memory: the clearing pass owns the write port after reset,
    // afterwards the finishing word does.
    assign mem_we    = r_clr_active || (finish && n_we);
    assign mem_waddr = r_clr_active ? r_clr_idx : r_ea;
    assign mem_wdata = r_clr_active ? 32'd0 : n_wdata;

    trsc_ram #(
        .WIDTH (trsc_pkg::WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (r_clr_active ? r_clr_idx : (i_cmd == trsc_pkg::CMD_STORE)
                                             ? AW'(i_addr) : in_ea_sum[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign o_valid        = r_o_valid;
    assign o_acc_a        = $signed(r_a);
    assign o_acc_b        = $signed(r_b);
    assign o_prog_counter = $signed(r_pc);
    assign o_stack_ptr    = $signed(r_sp);
    assign o_halted       = r_halt;
    assign o_access_kind  = r_kind;
    assign o_access_addr  = r_aaddr;
    assign o_access_old   = $signed(r_aold);
    assign o_access_data  = $signed(r_adata);

    // No word is taken while the memory is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !o_ready)
        else $error("word accepted during memory clear");

    // A read is never issued in the cycle of a write-back.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !(finish && n_we))
        else $error("memory read overlaps write-back");

    // An accepted word occupies the execute slot on the next cycle.
    a_slot_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("accepted word lost");

    // Halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    // A finishing word always shows up as a result.
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_valid)
        else $error("finished word produced no result");

endmodule

// ===== design/trsc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the data memory of the execute unit. No dependencies.
module trsc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/tb_two_register_stack_cpu_execute.sv =====
// Self-checking testbench for the two-register stack CPU execute unit.
// Drives memory-store and execute words with random handshake gaps and checks every
// result against a cycle-free state predictor. Depends on trsc_pkg and the RTL only.
module tb_two_register_stack_cpu_execute;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MEM_WORDS = trsc_pkg::MEM_WORDS_DEF;
    // Generous ceiling on simulated time, covering the clearing pass after reset
    // and the slowest legal run of the stimulus on top of that.
    localparam longint unsigned RUN_LIMIT_NS = 64'd6_000_000;

    // One input word as the driver presents it.
    typedef struct packed {
        logic        cmd;
        logic [15:0] addr;
        logic [31:0] word;
    } t_cpu_item;

    // Architectural state and access record expected after one input word.
    typedef struct {
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       pc;
        logic [31:0]       sp;
        logic              halted;
        trsc_pkg::t_access kind;
        logic [15:0]       aaddr;
        logic [31:0]       old;
        logic [31:0]       data;
    } t_cpu_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic i_cmd;
    logic [15:0] i_addr;
    logic [31:0] i_word;
    logic o_valid;
    logic i_ready;
    logic signed [31:0] o_acc_a;
    logic signed [31:0] o_acc_b;
    logic signed [31:0] o_prog_counter;
    logic signed [31:0] o_stack_ptr;
    logic o_halted;
    logic [1:0] o_access_kind;
    logic [15:0] o_access_addr;
    logic signed [31:0] o_access_old;
    logic signed [31:0] o_access_data;

    two_register_stack_cpu_execute #(
        .MEM_WORDS(MEM_WORDS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_cmd(i_cmd),
        .i_addr(i_addr),
        .i_word(i_word),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_acc_a(o_acc_a),
        .o_acc_b(o_acc_b),
        .o_prog_counter(o_prog_counter),
        .o_stack_ptr(o_stack_ptr),
        .o_halted(o_halted),
        .o_access_kind(o_access_kind),
        .o_access_addr(o_access_addr),
        .o_access_old(o_access_old),
        .o_access_data(o_access_data)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: a private copy of the registers and of the data memory.
    // The memory starts all zero, just as the block's clearing pass leaves it.
    bit [31:0]   mem_model [MEM_WORDS];
    logic [31:0] a_q = '0;
    logic [31:0] b_q = '0;
    logic [31:0] pc_q = '0;
    logic [31:0] sp_q = '0;
    logic        halt_q = 1'b0;

    t_cpu_item   program_q[$];      // words still to be driven
    t_cpu_result predicted_q[$];    // expected results, oldest first

    int unsigned n_items = 0;
    int unsigned n_taken = 0;
    int unsigned n_errors = 0;

    // Handshake bookkeeping for the two channels.
    logic        in_taken = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          in_burst = 1'b0;
    bit          out_burst = 1'b0;

    function automatic int unsigned mem_index(logic [31:0] x);
        return x % MEM_WORDS;
    endfunction

    // Apply one word to the predictor state and return what the block should report.
    function automatic t_cpu_result cpu_step(t_cpu_item it);
        t_cpu_result r;
        logic signed [31:0] sw;
        logic signed [31:0] sb;
        logic [31:0] operand;
        int unsigned ea;
        r.kind = trsc_pkg::ACC_NONE;
        r.aaddr = '0;
        r.old = '0;
        r.data = '0;
        if (it.cmd == trsc_pkg::CMD_STORE) begin
            // Stores go through even after a halt and never show up in the log.
            mem_model[mem_index({16'h0, it.addr})] = it.word;
        end else if (!halt_q) begin
            // The operand is the upper 24 bits, sign extended.
            sw = it.word;
            operand = sw >>> 8;
            pc_q = pc_q + 32'd1;
            case (it.word[7:0])
                trsc_pkg::OP_LDC: a_q = operand;
                trsc_pkg::OP_ADC: a_q = a_q + operand;
                trsc_pkg::OP_LDL: begin
                    ea = mem_index(sp_q + operand);
                    b_q = a_q;
                    a_q = mem_model[ea];
                    r.kind = trsc_pkg::ACC_READ;
                    r.aaddr = ea[15:0];
                    r.data = a_q;
                end
                trsc_pkg::OP_STL: begin
                    ea = mem_index(sp_q + operand);
                    r.old = mem_model[ea];
                    mem_model[ea] = a_q;
                    r.kind = trsc_pkg::ACC_WRITE;
                    r.aaddr = ea[15:0];
                    r.data = a_q;
                    a_q = b_q;
                end
                trsc_pkg::OP_LDNL: begin
                    ea = mem_index(a_q + operand);
                    a_q = mem_model[ea];
                    r.kind = trsc_pkg::ACC_READ;
                    r.aaddr = ea[15:0];
                    r.data = a_q;
                end
                trsc_pkg::OP_STNL: begin
                    ea = mem_index(a_q + operand);
                    r.old = mem_model[ea];
                    mem_model[ea] = b_q;
                    r.kind = trsc_pkg::ACC_WRITE;
                    r.aaddr = ea[15:0];
                    r.data = b_q;
                end
                trsc_pkg::OP_ADD: a_q = b_q + a_q;
                trsc_pkg::OP_SUB: a_q = b_q - a_q;
                trsc_pkg::OP_SHL: begin
                    if (a_q >= 32'd32) begin
                        a_q = '0;
                    end else begin
                        a_q = b_q << a_q[4:0];
                    end
                end
                trsc_pkg::OP_SHR: begin
                    // Counts of 32 and up leave only the sign of B.
                    sb = b_q;
                    if (a_q >= 32'd32) begin
                        a_q = {32{b_q[31]}};
                    end else begin
                        a_q = sb >>> a_q[4:0];
                    end
                end
                trsc_pkg::OP_ADJ: sp_q = sp_q + operand;
                trsc_pkg::OP_A2SP: begin
                    sp_q = a_q;
                    a_q = b_q;
                end
                trsc_pkg::OP_SP2A: begin
                    b_q = a_q;
                    a_q = sp_q;
                end
                trsc_pkg::OP_CALL: begin
                    b_q = a_q;
                    a_q = pc_q;
                    pc_q = pc_q + operand;
                end
                trsc_pkg::OP_RETURN: begin
                    pc_q = a_q;
                    a_q = b_q;
                end
                trsc_pkg::OP_BRZ: begin
                    if (a_q == 32'd0) pc_q = pc_q + operand;
                end
                trsc_pkg::OP_BRLZ: begin
                    if (a_q[31]) pc_q = pc_q + operand;
                end
                trsc_pkg::OP_BR: pc_q = pc_q + operand;
                trsc_pkg::OP_HALT: halt_q = 1'b1;
                default: ;
            endcase
        end
        r.a = a_q;
        r.b = b_q;
        r.pc = pc_q;
        r.sp = sp_q;
        r.halted = halt_q;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long pause.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic queue_store(logic [15:0] addr, logic [31:0] word);
        t_cpu_item it;
        it = '{trsc_pkg::CMD_STORE, addr, word};
        program_q.insert(program_q.size(), it);
    endtask

    // Execute word: opcode in the low byte, operand truncated to 24 bits above it.
    task automatic queue_exec(logic [7:0] opcode, int operand, logic [15:0] addr = 16'h0);
        t_cpu_item it;
        it = '{trsc_pkg::CMD_EXEC, addr, {operand[23:0], opcode}};
        program_q.insert(program_q.size(), it);
    endtask

    // Driver: presents the next word at the falling edge and holds it until taken.
    always @(negedge i_clk) begin : drive
        t_cpu_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (program_q.size() != 0) begin
                it = program_q.pop_front();
                i_cmd <= it.cmd;
                i_addr <= it.addr;
                i_word <= it.word;
                i_valid <= 1'b1;
                // Switch now and then into a stretch with no gaps at all.
                if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
                gap_left = in_burst ? 0 : idle_length();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure, also with stall-free stretches.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 127) == 0) out_burst = !out_burst;
            stall_left = (out_burst || $urandom_range(0, 2) != 0) ? 0 : idle_length();
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction, then
    // records an input word accepted at the same edge. A result always comes from a word
    // accepted at an earlier edge, so checking first keeps the order right.
    always @(posedge i_clk) begin : watch
        t_cpu_result exp_r;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (predicted_q.size() == 0) begin
                    $display("%0t ns: result with nothing expected: A %h PC %h", $time,
                             o_acc_a, o_prog_counter);
                    n_errors++;
                end else begin
                    exp_r = predicted_q.pop_front();
                    check_field("acc_a", exp_r.a, o_acc_a);
                    check_field("acc_b", exp_r.b, o_acc_b);
                    check_field("prog_counter", exp_r.pc, o_prog_counter);
                    check_field("stack_ptr", exp_r.sp, o_stack_ptr);
                    check_field("halted", {31'h0, exp_r.halted}, {31'h0, o_halted});
                    check_field("access_kind", {30'h0, exp_r.kind}, {30'h0, o_access_kind});
                    check_field("access_addr", {16'h0, exp_r.aaddr}, {16'h0, o_access_addr});
                    check_field("access_old", exp_r.old, o_access_old);
                    check_field("access_data", exp_r.data, o_access_data);
                end
            end
            in_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                predicted_q.insert(predicted_q.size(), cpu_step('{i_cmd, i_addr, i_word}));
                n_taken++;
            end
        end
    end

    initial begin
        int unsigned pick;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cmd = trsc_pkg::CMD_STORE;
        i_addr = '0;
        i_word = '0;

        // Directed part. Seed memory at both ends of the address range.
        queue_store(16'h0000, 32'hFFFF_FFFF);
        queue_store(16'hFFFF, 32'h8000_0001);
        queue_store(16'h0005, 32'h1234_5678);
        // Largest positive operand, then the most negative one: A ends at -1.
        queue_exec(trsc_pkg::OP_LDC, 32'h007F_FFFF);
        queue_exec(trsc_pkg::OP_ADC, 32'h0080_0000);
        queue_exec(trsc_pkg::OP_ADJ, 5);
        queue_exec(trsc_pkg::OP_LDL, 0);
        // SP - 6 wraps below zero to the top word of memory.
        queue_exec(trsc_pkg::OP_LDL, -6);
        queue_exec(trsc_pkg::OP_STL, 1);
        // Indirect read: A + offset lands exactly on word 0.
        queue_exec(trsc_pkg::OP_LDNL, -32'sh5678);
        // Indirect write with A = -1: the address wraps around to word 0.
        queue_exec(trsc_pkg::OP_STNL, 1);
        queue_exec(trsc_pkg::OP_ADD, 0);
        queue_exec(trsc_pkg::OP_SUB, 0);
        // Put a negative value in B for the shifts.
        queue_exec(trsc_pkg::OP_LDC, -3);
        queue_exec(trsc_pkg::OP_SP2A, 0);
        queue_exec(trsc_pkg::OP_SHR, 0);
        queue_exec(trsc_pkg::OP_LDC, 32);
        queue_exec(trsc_pkg::OP_SHL, 0);
        // A huge count on a negative B gives the sign fill.
        queue_exec(trsc_pkg::OP_LDC, -1);
        queue_exec(trsc_pkg::OP_SHR, 0);
        queue_exec(trsc_pkg::OP_LDC, 31);
        queue_exec(trsc_pkg::OP_SHL, 0);
        queue_exec(trsc_pkg::OP_A2SP, 0);
        queue_exec(trsc_pkg::OP_CALL, 3);
        queue_exec(trsc_pkg::OP_RETURN, 0);
        queue_exec(trsc_pkg::OP_LDC, 0);
        queue_exec(trsc_pkg::OP_BRZ, 4);
        queue_exec(trsc_pkg::OP_LDC, -1);
        queue_exec(trsc_pkg::OP_BRLZ, -2);
        queue_exec(trsc_pkg::OP_BR, -7);
        // An opcode outside the instruction set only bumps PC.
        queue_exec(8'hFF, 32'h00AB_CDEF);
        // Bring SP back near zero so that random stack accesses hit stored words.
        queue_exec(trsc_pkg::OP_LDC, 16);
        queue_exec(trsc_pkg::OP_A2SP, 0);

        // Random part. Halt is sticky and reset happens only once, so halt is kept
        // out of here and exercised at the very end. Addresses and operands lean
        // small so loads read back words that earlier items wrote.
        repeat (500) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                queue_store(($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 127))
                                                         : 16'($urandom_range(0, 65535)),
                            ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 127)) - 32'd64
                                                         : $urandom());
            end else if (pick < 26) begin
                // Noise: opcodes past the end of the set, random content throughout.
                queue_exec(8'($urandom_range(trsc_pkg::OP_HALT + 1, 255)), $urandom(),
                           16'($urandom_range(0, 65535)));
            end else begin
                queue_exec(8'($urandom_range(trsc_pkg::OP_LDC, trsc_pkg::OP_BR)),
                           ($urandom_range(0, 9) < 7) ? $urandom_range(0, 127) - 64
                                                       : $urandom(),
                           16'($urandom_range(0, 65535)));
            end
        end

        // Halt, then executes that must be ignored, and a store that still lands.
        queue_exec(trsc_pkg::OP_HALT, $urandom());
        queue_exec(trsc_pkg::OP_LDC, 9);
        queue_store(16'h1234, $urandom());
        queue_exec(trsc_pkg::OP_STL, 0);
        queue_exec(trsc_pkg::OP_LDL, 0);
        n_items = program_q.size();

        // Reset is held low for a while and released at a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_items) @(posedge i_clk);
        while (predicted_q.size() != 0) @(posedge i_clk);
        // Keep watching a little longer to catch any stray result.
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS * 1ns);
        $display("tb: failure");
        $finish;
    end

endmodule
